>>> design/lkpt_pkg.sv
// shared types and constants for the keyed lru pool table
`default_nettype none
package lkpt_pkg;

    localparam int DIM_W      = 16;
    localparam int FMT_W      = 5;
    localparam int SLOT_OUT_W = 4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic scan;
        logic update;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
    } t_status;

endpackage
`default_nettype wire

>>> design/lru_keyed_pool_table_core.sv
// top level of the two-bank keyed lru pool table
// flow: the request is loaded on the accepting edge, the selected bank is scanned, then the list
//   and key ram are updated and the result is shown; a miss scans every entry, a hit stops early
// throughput: one transaction at a time; the key ram scan, one slot per cycle through its single
//   read port, sets the pace
// reset: synchronous active low, both bank counters clear; the receiver cannot stall
`default_nettype none
module lru_keyed_pool_table_core #(
    parameter int TABLE_ENTRIES = 16,
    parameter int WIDTH_BITS    = 16,
    parameter int FORMAT_BITS   = 5
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // request transaction
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [lkpt_pkg::DIM_W-1:0]    i_frame_width,
    input  wire logic [lkpt_pkg::DIM_W-1:0]    i_frame_height,
    input  wire logic [lkpt_pkg::FMT_W-1:0]    i_pixel_format,
    input  wire logic                          i_bank_gpu,
    // result transaction, one cycle strobe
    output logic                               o_valid,
    output logic                               o_hit,
    output logic [lkpt_pkg::SLOT_OUT_W-1:0]    o_slot,
    output logic                               o_evicted,
    output logic [lkpt_pkg::DIM_W-1:0]         o_evicted_width,
    output logic [lkpt_pkg::DIM_W-1:0]         o_evicted_height,
    output logic [lkpt_pkg::FMT_W-1:0]         o_evicted_format
);

    // command and status between the sequencer and the datapath
    lkpt_pkg::t_cmd    cmd;
    lkpt_pkg::t_status status;

    // sequencer: idle, scan the selected bank, update list and key ram, show result
    lkpt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_status(status),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    // datapath: key ram scanned one slot per cycle, recency list shifted in the update state,
    // lru key captured as the scan passes it so an eviction needs no extra read
    lkpt_datapath #(
        .N (TABLE_ENTRIES),
        .WB(WIDTH_BITS),
        .FB(FORMAT_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_frame_width   (i_frame_width),
        .i_frame_height  (i_frame_height),
        .i_pixel_format  (i_pixel_format),
        .i_bank_gpu      (i_bank_gpu),
        .o_hit           (o_hit),
        .o_slot          (o_slot),
        .o_evicted       (o_evicted),
        .o_evicted_width (o_evicted_width),
        .o_evicted_height(o_evicted_height),
        .o_evicted_format(o_evicted_format)
    );

    // result strobe is a single pulse, never held high
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for two cycles");

    // a result always follows the update cycle of the sequencer
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without preceding work");

    // a hit never evicts
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit) |-> !o_evicted)
        else $error("eviction reported on a hit");

    // no eviction means zero evicted width and format
    a_evict_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_evicted) |-> (o_evicted_width == '0 && o_evicted_format == '0))
        else $error("evicted key nonzero without eviction");

endmodule
`default_nettype wire

>>> design/lkpt_ram.sv
// generic simple dual port ram with registered read
`default_nettype none
module lkpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

>>> design/lkpt_ctrl.sv
// controller state machine for the keyed lru pool table
`default_nettype none
module lkpt_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire lkpt_pkg::t_status i_status,
    output lkpt_pkg::t_cmd         o_cmd,
    output logic                   o_busy,
    output logic                   o_valid
);

    lkpt_pkg::t_state r_state;
    lkpt_pkg::t_state n_state;
    logic             accept;

    assign accept = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lkpt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            lkpt_pkg::ST_IDLE: begin
                if (accept) n_state = lkpt_pkg::ST_SCAN;
            end
            lkpt_pkg::ST_SCAN: begin
                if (i_status.scan_done) n_state = lkpt_pkg::ST_UPDATE;
            end
            lkpt_pkg::ST_UPDATE: begin
                n_state = lkpt_pkg::ST_DONE;
            end
            lkpt_pkg::ST_DONE: begin
                n_state = accept ? lkpt_pkg::ST_SCAN : lkpt_pkg::ST_IDLE;
            end
            default: begin
                n_state = lkpt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_busy       = 1'b0;
        o_valid      = 1'b0;
        o_cmd.scan   = 1'b0;
        o_cmd.update = 1'b0;
        case (r_state)
            lkpt_pkg::ST_IDLE:   o_busy = 1'b0;
            lkpt_pkg::ST_SCAN: begin
                o_busy     = 1'b1;
                o_cmd.scan = 1'b1;
            end
            lkpt_pkg::ST_UPDATE: begin
                o_busy       = 1'b1;
                o_cmd.update = 1'b1;
            end
            lkpt_pkg::ST_DONE:   o_valid = 1'b1;
            default:             o_busy = 1'b0;
        endcase
        o_cmd.load = i_start && !o_busy;
    end

endmodule
`default_nettype wire

>>> design/lkpt_datapath.sv
// key store, recency list, bank counters and result registers
`default_nettype none
module lkpt_datapath #(
    parameter int N  = 16,
    parameter int WB = 16,
    parameter int FB = 5
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire lkpt_pkg::t_cmd                i_cmd,
    output lkpt_pkg::t_status                  o_status,
    input  wire logic [lkpt_pkg::DIM_W-1:0]    i_frame_width,
    input  wire logic [lkpt_pkg::DIM_W-1:0]    i_frame_height,
    input  wire logic [lkpt_pkg::FMT_W-1:0]    i_pixel_format,
    input  wire logic                          i_bank_gpu,
    output logic                               o_hit,
    output logic [lkpt_pkg::SLOT_OUT_W-1:0]    o_slot,
    output logic                               o_evicted,
    output logic [lkpt_pkg::DIM_W-1:0]         o_evicted_width,
    output logic [lkpt_pkg::DIM_W-1:0]         o_evicted_height,
    output logic [lkpt_pkg::FMT_W-1:0]         o_evicted_format
);

    localparam int DW     = lkpt_pkg::DIM_W;
    localparam int FW     = lkpt_pkg::FMT_W;
    localparam int SO_W   = lkpt_pkg::SLOT_OUT_W;
    localparam int SLOT_W = (N > 1) ? $clog2(N) : 1;
    localparam int CNT_W  = $clog2(N + 1);
    localparam int KEY_W  = 2 * WB + FB;
    localparam int ADDR_W = SLOT_W + 1;
    localparam int DEPTH  = 1 << ADDR_W;

    logic [CNT_W-1:0]  r_count [2];
    logic [CNT_W-1:0]  r_n;
    logic [CNT_W-1:0]  r_idx;
    logic              r_bank;
    logic [KEY_W-1:0]  r_key;
    logic              r_cmp_vld;
    logic [SLOT_W-1:0] r_cmp_slot;
    logic              r_hit;
    logic [SLOT_W-1:0] r_slot;
    logic [KEY_W-1:0]  r_lru_key;
    logic [SLOT_W-1:0] r_rec [2][N];

    logic [KEY_W-1:0]  rd_data;
    logic [SLOT_W-1:0] rec_b  [N];
    logic [SLOT_W-1:0] rec_up [N];
    logic [SLOT_W-1:0] n_rec  [N];
    logic [N-1:0]      eq;
    logic [N-1:0]      ge;
    logic              issue;
    logic              match;
    logic              full;
    logic              promote;
    logic              evict;
    logic [SLOT_W-1:0] sel;
    logic [SLOT_W-1:0] new_slot;
    logic [SLOT_W-1:0] slot_final;
    logic [CNT_W-1:0]  n_m1;
    logic              we;

    always_comb begin
        for (int j = 0; j < N; j++) begin
            rec_b[j] = r_rec[r_bank][j];
        end
    end

    assign issue      = r_idx < r_n;
    assign match      = r_cmp_vld && (rd_data == r_key);
    assign full       = r_n == CNT_W'(N);
    assign promote    = r_hit || full;
    assign evict      = !r_hit && full;
    assign sel        = r_hit ? r_slot : rec_b[0];
    assign new_slot   = r_n[SLOT_W-1:0];
    assign slot_final = promote ? sel : new_slot;
    assign n_m1       = r_n - 1'b1;
    assign we         = i_cmd.update && !r_hit;

    assign o_status.scan_done = match || (!issue && !r_cmp_vld);

    // position of the promoted slot and everything above it in the list
    always_comb begin
        for (int j = 0; j < N; j++) begin
            eq[j] = (rec_b[j] == sel) && (CNT_W'(j) < r_n);
        end
        for (int j = 0; j < N; j++) begin
            ge[j] = 1'b0;
            for (int k = 0; k <= j; k++) begin
                ge[j] = ge[j] | eq[k];
            end
        end
        for (int j = 0; j < N - 1; j++) begin
            rec_up[j] = rec_b[j + 1];
        end
        rec_up[N-1] = rec_b[N-1];
        for (int j = 0; j < N; j++) begin
            n_rec[j] = rec_b[j];
            if (promote) begin
                if (CNT_W'(j) == n_m1) begin
                    n_rec[j] = sel;
                end else if (ge[j] && (CNT_W'(j) < n_m1)) begin
                    n_rec[j] = rec_up[j];
                end
            end else if (CNT_W'(j) == r_n) begin
                n_rec[j] = new_slot;
            end
        end
    end

    lkpt_ram #(
        .WIDTH(KEY_W),
        .DEPTH(DEPTH)
    ) u_key_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr({r_bank, slot_final}),
        .i_wdata(r_key),
        .i_raddr({r_bank, r_idx[SLOT_W-1:0]}),
        .o_rdata(rd_data)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count[0] <= '0;
            r_count[1] <= '0;
            r_idx      <= '0;
            r_n        <= '0;
            r_cmp_vld  <= 1'b0;
            r_hit      <= 1'b0;
        end else if (i_cmd.load) begin
            r_n       <= r_count[i_bank_gpu];
            r_idx     <= '0;
            r_cmp_vld <= 1'b0;
            r_hit     <= 1'b0;
        end else if (i_cmd.scan) begin
            r_cmp_vld <= issue;
            if (issue) r_idx <= r_idx + 1'b1;
            if (match) r_hit <= 1'b1;
        end else if (i_cmd.update) begin
            if (!promote) r_count[r_bank] <= r_n + 1'b1;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bank <= i_bank_gpu;
            r_key  <= {WB'(i_frame_width), WB'(i_frame_height), FB'(i_pixel_format)};
        end
        if (i_cmd.scan) begin
            r_cmp_slot <= r_idx[SLOT_W-1:0];
            if (match) r_slot <= r_cmp_slot;
            if (r_cmp_vld && (r_cmp_slot == rec_b[0])) r_lru_key <= rd_data;
        end
        if (i_cmd.update) begin
            for (int j = 0; j < N; j++) begin
                r_rec[r_bank][j] <= n_rec[j];
            end
            o_hit     <= r_hit;
            o_slot    <= SO_W'(slot_final);
            o_evicted <= evict;
            if (evict) begin
                o_evicted_width  <= DW'(r_lru_key[KEY_W-1 -: WB]);
                o_evicted_height <= DW'(r_lru_key[FB +: WB]);
                o_evicted_format <= FW'(r_lru_key[FB-1:0]);
            end else begin
                o_evicted_width  <= '0;
                o_evicted_height <= '0;
                o_evicted_format <= '0;
            end
        end
    end

endmodule
`default_nettype wire
